// ===== sv/llqd_pkg.sv =====
// shared types and constants of the least-loaded queue dispatcher
package llqd_pkg;

    localparam int TASK_W   = 16;
    localparam int ENTRY_W  = 2 * TASK_W;
    localparam int SERVER_W = 2;
    localparam int SIU_W    = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SIU_W-1:0] SIU_RESET = 3'd3;

    localparam logic KIND_DISPATCH = 1'b0;
    localparam logic KIND_DRAIN    = 1'b1;

    typedef enum logic [1:0] {
        EV_ASSIGNED = 2'd0,
        EV_DRAINED  = 2'd1,
        EV_REJECTED = 2'd2
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DISP = 4'b0010,
        S_SCAN = 4'b0100,
        S_DOUT = 4'b1000
    } t_state;

endpackage

// ===== sv/least_loaded_queue_dispatcher_core.sv =====
// join-shortest-queue dispatcher: per-server task fifos in one ram, apb setup register
//
// Every server owns a fifo of QUEUE_DEPTH slots in a single ram of NUM_SERVERS*QUEUE_DEPTH
// words; fill counts and head pointers sit in flip-flops. In a dispatch beat the idle state
// picks the least-filled server in use through a compare tree over the counts, then the
// dispatch state writes the task into the ram, unless that queue is full and the task is
// rejected, and loads the result register. A drain beat walks the servers in use in order:
// per queued task the scan state issues the ram read, then the output state loads the
// result; a server in use found empty is passed over in the scan state. A stalled output
// holds the dispatch and output states. A new input beat is taken as soon as the previous
// item is done, even while its last result still waits on the output. The ram holds no
// reset value and needs no clearing pass; only occupied slots are ever read.
module least_loaded_queue_dispatcher_core
    import llqd_pkg::*;
#(
    parameter int NUM_SERVERS = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [TASK_W-1:0]   i_task_id,
    input  logic [TASK_W-1:0]   i_task_load,

    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_event_res,
    output logic [SERVER_W-1:0] o_server,
    output logic [TASK_W-1:0]   o_out_task_id,
    output logic [TASK_W-1:0]   o_out_task_load,
    output logic                o_last,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int SW        = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int PW        = $clog2(NUM_SERVERS + 1);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int HW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MEM_DEPTH = NUM_SERVERS * QUEUE_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LW        = $clog2(NUM_SERVERS);
    localparam int PAD       = 1 << LW;
    localparam int KW        = CW + 1;

    t_state              r_state;
    logic [SIU_W-1:0]    r_siu;
    logic [PW-1:0]       r_ptr;
    logic [CW-1:0]       r_cnt  [NUM_SERVERS];
    logic [HW-1:0]       r_head [NUM_SERVERS];
    logic [TASK_W-1:0]   r_id;
    logic [TASK_W-1:0]   r_load;

    logic                r_o_valid;
    t_event              r_o_event;
    logic [SERVER_W-1:0] r_o_server;
    logic [TASK_W-1:0]   r_o_id;
    logic [TASK_W-1:0]   r_o_load;
    logic                r_o_last;

    logic [PW-1:0]       n_act;
    logic [SW-1:0]       sel;
    logic [CW-1:0]       cnt_sel;
    logic [HW-1:0]       head_sel;
    logic [HW-1:0]       head_next;
    logic [CW:0]         slot_sum;
    logic [HW-1:0]       slot;
    logic                sel_full;
    logic                ptr_ok;
    logic                out_free;
    logic                out_load;
    logic                cfg_wr;
    logic                later_busy;
    logic                drain_last;
    logic [SW+1:0]       srv_wide;
    logic [SW-1:0]       best_idx;
    logic [KW-1:0]       tr_key [2*PAD];
    logic [SW-1:0]       tr_idx [2*PAD];

    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // config port
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {{(PDATA_W-SIU_W){1'b0}}, r_siu};

    always_comb begin
        if (r_siu == '0) begin
            n_act = PW'(1);
        end else if (int'(r_siu) > NUM_SERVERS) begin
            n_act = PW'(NUM_SERVERS);
        end else begin
            n_act = PW'(r_siu);
        end
    end

    // least-filled server in use, ties to the lower index
    always_comb begin
        for (int k = 0; k < 2 * PAD; k++) begin
            tr_key[k] = '1;
            tr_idx[k] = '0;
        end
        for (int i = 0; i < NUM_SERVERS; i++) begin
            tr_idx[PAD+i] = SW'(i);
            if (PW'(i) < n_act) begin
                tr_key[PAD+i] = {1'b0, r_cnt[i]};
            end
        end
        for (int k = PAD - 1; k >= 1; k--) begin
            if (tr_key[2*k] <= tr_key[2*k+1]) begin
                tr_key[k] = tr_key[2*k];
                tr_idx[k] = tr_idx[2*k];
            end else begin
                tr_key[k] = tr_key[2*k+1];
                tr_idx[k] = tr_idx[2*k+1];
            end
        end
        best_idx = tr_idx[1];
    end

    // selected server
    assign sel      = r_ptr[SW-1:0];
    assign cnt_sel  = r_cnt[sel];
    assign head_sel = r_head[sel];
    assign sel_full = (cnt_sel == CW'(QUEUE_DEPTH));
    assign ptr_ok   = (r_ptr < n_act);
    assign srv_wide = {2'b00, sel};

    always_comb begin
        slot_sum = (CW+1)'(head_sel) + (CW+1)'(cnt_sel);
        if (slot_sum >= (CW+1)'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - (CW+1)'(QUEUE_DEPTH);
        end
        slot = slot_sum[HW-1:0];
    end

    assign head_next = (head_sel == HW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + HW'(1);

    always_comb begin
        later_busy = 1'b0;
        for (int s = 0; s < NUM_SERVERS; s++) begin
            if (PW'(s) > r_ptr && PW'(s) < n_act && r_cnt[s] != '0) begin
                later_busy = 1'b1;
            end
        end
    end

    assign drain_last = (cnt_sel == CW'(1)) && !later_busy;
    assign out_free   = !r_o_valid || !i_stall;
    assign out_load   = ((r_state == S_DISP) || (r_state == S_DOUT)) && out_free;

    // task store
    assign ram_we    = (r_state == S_DISP) && out_free && !sel_full;
    assign ram_re    = (r_state == S_SCAN) && ptr_ok && (cnt_sel != '0);
    assign ram_waddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(slot);
    assign ram_raddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(head_sel);

    llqd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_id, r_load}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_siu     <= SIU_RESET;
            r_ptr     <= '0;
            r_o_valid <= 1'b0;
            for (int s = 0; s < NUM_SERVERS; s++) begin
                r_cnt[s]  <= '0;
                r_head[s] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_siu <= pwdata[SIU_W-1:0];
            end
            if (r_o_valid && !i_stall && !out_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_id   <= i_task_id;
                        r_load <= i_task_load;
                        if (i_kind == KIND_DRAIN) begin
                            r_ptr   <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_ptr   <= PW'(best_idx);
                            r_state <= S_DISP;
                        end
                    end
                end
                S_DISP: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_server <= srv_wide[SERVER_W-1:0];
                        r_o_id     <= r_id;
                        r_o_load   <= r_load;
                        r_o_last   <= 1'b1;
                        if (sel_full) begin
                            r_o_event <= EV_REJECTED;
                        end else begin
                            r_o_event  <= EV_ASSIGNED;
                            r_cnt[sel] <= cnt_sel + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!ptr_ok) begin
                        r_state <= S_IDLE;
                    end else if (cnt_sel == '0) begin
                        r_head[sel] <= '0;
                        r_ptr       <= r_ptr + PW'(1);
                    end else begin
                        r_state <= S_DOUT;
                    end
                end
                S_DOUT: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_event  <= EV_DRAINED;
                        r_o_server <= srv_wide[SERVER_W-1:0];
                        r_o_id     <= ram_rdata[ENTRY_W-1:TASK_W];
                        r_o_load   <= ram_rdata[TASK_W-1:0];
                        r_o_last   <= drain_last;
                        if (cnt_sel == CW'(1)) begin
                            r_cnt[sel]  <= '0;
                            r_head[sel] <= '0;
                            r_ptr       <= r_ptr + PW'(1);
                        end else begin
                            r_cnt[sel]  <= cnt_sel - CW'(1);
                            r_head[sel] <= head_next;
                        end
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_event_res     = r_o_event;
    assign o_server        = r_o_server;
    assign o_out_task_id   = r_o_id;
    assign o_out_task_load = r_o_load;
    assign o_last          = r_o_last;

`ifndef NO_ASSERTIONS
    a_disp_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP && out_free) |=> (r_o_valid && r_o_last && r_state == S_IDLE))
        else $error("dispatch finished without a final result");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_sel <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUT && $past(r_state == S_DOUT)) |-> $stable(ram_rdata))
        else $error("read data changed while result waits");
`endif

endmodule

// ===== sv/llqd_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module llqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
